// ===== sv/tsm_pkg.sv =====
// Package for the trigger sequence matcher.
// Holds the channel field widths, step kind codes and register indexes.
// No dependencies; compile first.
package tsm_pkg;

    // Fixed geometry of the packed configuration registers
    localparam int unsigned FIELD_SLOTS = 4;
    localparam int unsigned SLOT_BITS   = 16;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned STEP_W      = 2;
    localparam int unsigned COND_W      = 4;
    localparam int unsigned COUNT_REG_W = 3;
    localparam int unsigned KINDS_W     = 8;

    typedef logic [STEP_W-1:0]      step_idx_t;
    typedef logic [COND_W-1:0]      cond_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // Step kind codes (the spare code behaves as wait)
    typedef enum logic [1:0] {
        STEP_WAIT   = 2'd0,
        STEP_WITHIN = 2'd1,
        STEP_HOLD   = 2'd2,
        STEP_SPARE  = 2'd3
    } step_kind_t;

    // Input beat kinds
    localparam logic ITEM_TICK  = 1'b0;
    localparam logic ITEM_REARM = 1'b1;

    // Configuration register indexes
    localparam cfg_index_t REG_STEP_COUNT     = 3'd0;
    localparam cfg_index_t REG_STEP_KINDS     = 3'd1;
    localparam cfg_index_t REG_WITHIN_MINIMUM = 3'd2;
    localparam cfg_index_t REG_WITHIN_MAXIMUM = 3'd3;
    localparam cfg_index_t REG_HOLD_CYCLES    = 3'd4;

endpackage

// ===== sv/tsm_if.sv =====
// Channel interfaces of the trigger sequence matcher: tick input,
// result output and configuration write.
// Depends on tsm_pkg.
interface tsm_tick_if;
    import tsm_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    cond_t cond_bits;

    modport source (output valid, output kind, output cond_bits, input ready);
    modport sink   (input valid, input kind, input cond_bits, output ready);
endinterface

interface tsm_result_if;
    import tsm_pkg::*;

    logic      valid;
    logic      ready;
    logic      hit;
    logic      rearm_accepted;
    logic      armed_now;
    step_idx_t current_step;

    modport source (output valid, output hit, output rearm_accepted, output armed_now,
                    output current_step, input ready);
    modport sink   (input valid, input hit, input rearm_accepted, input armed_now,
                    input current_step, output ready);
endinterface

interface tsm_cfg_if;
    import tsm_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/trigger_sequence_matcher.sv =====
// Top level of the trigger sequence matcher: input stage, step evaluation
// and result register. Depends on tsm_pkg and the interfaces in tsm_if.sv.
//
//   channel   dir  beat carries
//   --------  ---  ------------------------------------------------
//   ticks     in   kind, cond_bits
//   results   out  hit, rearm_accepted, armed_now, current_step
//   cfg       in   index, data (always ready)
//
// One beat per cycle while the result channel is not stalled: a beat is
// captured in the input stage, evaluated against the sequencer state and
// written to the result register.
// Reset (rst_n low, async) arms the block at step 0 with step_count 1.
// A stalled result register holds the input stage; ticks.ready falls
// only when both are full.
module trigger_sequence_matcher #(
    parameter int unsigned MAX_STEPS   = 4,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    tsm_tick_if.sink            ticks,
    tsm_result_if.source        results,
    tsm_cfg_if.sink             cfg
);
    import tsm_pkg::*;

    localparam int unsigned LIM_W = (COUNT_WIDTH < SLOT_BITS) ? COUNT_WIDTH : SLOT_BITS;
    localparam int unsigned AGE_W = COUNT_WIDTH + 1;
    localparam int unsigned CAP   = (MAX_STEPS < FIELD_SLOTS) ? MAX_STEPS : FIELD_SLOTS;
    localparam logic [COUNT_REG_W-1:0] CAP_N = COUNT_REG_W'(CAP);

    typedef logic [LIM_W-1:0] limit_t;

    // Configuration registers
    logic [COUNT_REG_W-1:0] step_count_reg;
    logic [KINDS_W-1:0]     step_kinds_reg;
    limit_t                 win_min_reg [FIELD_SLOTS];
    limit_t                 win_max_reg [FIELD_SLOTS];
    limit_t                 hold_reg    [FIELD_SLOTS];

    // Sequencer state
    step_idx_t              step_index_reg, step_index_next;
    logic [AGE_W-1:0]       age_reg, age_next;
    logic [COUNT_WIDTH-1:0] held_reg, held_next;
    logic                   armed_reg, armed_next;

    // Input stage
    logic  st_valid_reg;
    logic  st_kind_reg;
    cond_t st_cond_reg;

    // Result register
    logic      res_valid_reg;
    logic      res_hit_reg, res_hit_next;
    logic      res_acc_reg, res_acc_next;
    logic      res_armed_reg;
    step_idx_t res_step_reg;

    logic res_load_ok;
    logic st_fire;
    logic st_load_ok;

    assign res_load_ok = !res_valid_reg || results.ready;
    assign st_fire     = st_valid_reg && res_load_ok;
    assign st_load_ok  = !st_valid_reg || res_load_ok;
    assign ticks.ready = st_load_ok;
    assign cfg.ready   = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= COUNT_REG_W'(1);
            step_kinds_reg <= '0;
            for (int i = 0; i < FIELD_SLOTS; i++)
            begin
                win_min_reg[i] <= '0;
                win_max_reg[i] <= '0;
                hold_reg[i]    <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_STEP_COUNT:     step_count_reg <= cfg.data[COUNT_REG_W-1:0];
                REG_STEP_KINDS:     step_kinds_reg <= cfg.data[KINDS_W-1:0];
                REG_WITHIN_MINIMUM:
                begin
                    for (int i = 0; i < FIELD_SLOTS; i++)
                        win_min_reg[i] <= cfg.data[i*SLOT_BITS +: LIM_W];
                end
                REG_WITHIN_MAXIMUM:
                begin
                    for (int i = 0; i < FIELD_SLOTS; i++)
                        win_max_reg[i] <= cfg.data[i*SLOT_BITS +: LIM_W];
                end
                REG_HOLD_CYCLES:
                begin
                    for (int i = 0; i < FIELD_SLOTS; i++)
                        hold_reg[i] <= cfg.data[i*SLOT_BITS +: LIM_W];
                end
                default: ;
            endcase
        end
    end

    // Capture an input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (st_load_ok)
            st_valid_reg <= ticks.valid;
    end

    always_ff @(posedge clk)
    begin
        if (st_load_ok && ticks.valid)
        begin
            st_kind_reg <= ticks.kind;
            st_cond_reg <= ticks.cond_bits;
        end
    end

    // Evaluate the current step
    logic [COUNT_REG_W-1:0] steps_used;
    step_kind_t             cur_kind;
    logic                   cur_cond;
    logic [AGE_W-1:0]       age_inc;
    logic [COUNT_WIDTH-1:0] held_inc;
    logic                   done;

    always_comb
    begin
        if (step_count_reg == '0)
            steps_used = COUNT_REG_W'(1);
        else if (step_count_reg > CAP_N)
            steps_used = CAP_N;
        else
            steps_used = step_count_reg;

        cur_kind = step_kind_t'(step_kinds_reg[{step_index_reg, 1'b0} +: 2]);
        cur_cond = st_cond_reg[step_index_reg];
        age_inc  = (age_reg != '1) ? age_reg + AGE_W'(1) : age_reg;
        held_inc = !cur_cond ? '0
                 : (held_reg != '1) ? held_reg + COUNT_WIDTH'(1) : held_reg;

        step_index_next = step_index_reg;
        age_next        = age_reg;
        held_next       = held_reg;
        armed_next      = armed_reg;
        res_hit_next    = 1'b0;
        res_acc_next    = 1'b0;
        done            = 1'b0;

        if (st_kind_reg == ITEM_REARM)
        begin
            // Rearm only a disarmed block
            if (!armed_reg)
            begin
                armed_next      = 1'b1;
                step_index_next = '0;
                age_next        = '0;
                held_next       = '0;
                res_acc_next    = 1'b1;
            end
        end
        else if (armed_reg)
        begin
            case (cur_kind)
                STEP_WITHIN:
                begin
                    if (age_inc > AGE_W'(win_max_reg[step_index_reg]))
                    begin
                        // Window expired: restart the sequence
                        step_index_next = '0;
                        age_next        = '0;
                        held_next       = '0;
                    end
                    else
                    begin
                        age_next = age_inc;
                        done     = (age_inc >= AGE_W'(win_min_reg[step_index_reg]))
                                   && cur_cond;
                    end
                end
                STEP_HOLD:
                begin
                    held_next = held_inc;
                    done      = held_inc >= COUNT_WIDTH'(hold_reg[step_index_reg]);
                end
                default:
                    done = cur_cond;
            endcase

            // Advance, or finish and disarm on the last step
            if (done)
            begin
                age_next  = '0;
                held_next = '0;
                if ({1'b0, step_index_reg} + COUNT_REG_W'(1) >= steps_used)
                begin
                    step_index_next = '0;
                    armed_next      = 1'b0;
                    res_hit_next    = 1'b1;
                end
                else
                    step_index_next = step_index_reg + STEP_W'(1);
            end
        end
    end

    // Update sequencer state on each evaluated beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg <= '0;
            age_reg        <= '0;
            held_reg       <= '0;
            armed_reg      <= 1'b1;
        end
        else if (st_fire)
        begin
            step_index_reg <= step_index_next;
            age_reg        <= age_next;
            held_reg       <= held_next;
            armed_reg      <= armed_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load_ok)
            res_valid_reg <= st_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (st_fire)
        begin
            res_hit_reg   <= res_hit_next;
            res_acc_reg   <= res_acc_next;
            res_armed_reg <= armed_next;
            res_step_reg  <= step_index_next;
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.hit            = res_hit_reg;
    assign results.rearm_accepted = res_acc_reg;
    assign results.armed_now      = res_armed_reg;
    assign results.current_step   = res_step_reg;

endmodule

// ===== tb/trigger_sequence_matcher_test.sv =====
// Self-checking testbench for trigger_sequence_matcher: directed step-kind cases,
// then random trigger sequences under several idle and stall mixes.
// Depends on tsm_pkg and the channel interfaces in tsm_if.sv.
module trigger_sequence_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsm_pkg::*;

    localparam int unsigned TB_MAX_STEPS   = 4;
    localparam int unsigned TB_COUNT_WIDTH = 16;
    localparam logic [16:0] AGE_TOP        = 17'h1FFFF;
    localparam logic [15:0] HELD_TOP       = 16'hFFFF;
    localparam int unsigned CYCLE_LIMIT    = 300000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    // Indexes past the last register; writes there must change nothing
    localparam cfg_index_t REG_UNUSED_LO   = 3'd5;
    localparam cfg_index_t REG_UNUSED_HI   = 3'd7;

    typedef struct packed {
        logic      hit;
        logic      rearm_accepted;
        logic      armed_now;
        step_idx_t current_step;
    } match_result_t;

    logic clk;
    logic rst_n;

    tsm_tick_if   tick_ch ();
    tsm_result_if result_ch ();
    tsm_cfg_if    cfg_ch ();

    trigger_sequence_matcher #(
        .MAX_STEPS   (TB_MAX_STEPS),
        .COUNT_WIDTH (TB_COUNT_WIDTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .ticks   (tick_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // Sequencer copy: registers and progress
    logic [2:0]  cfg_count = 3'd1;
    logic [7:0]  cfg_kinds = '0;
    cfg_data_t   cfg_min   = '0;
    cfg_data_t   cfg_max   = '0;
    cfg_data_t   cfg_hold  = '0;
    step_idx_t   seq_step  = '0;
    logic [16:0] seq_age   = '0;
    logic [15:0] seq_held  = '0;
    logic        seq_armed = 1'b1;

    match_result_t pending_matches[$];
    match_result_t want;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   hold_off_left  = 0;

    // Clock: 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void restart_sequence();
        seq_step = '0;
        seq_age  = '0;
        seq_held = '0;
    endfunction

    function automatic int unsigned active_steps();
        int unsigned n;
        n = cfg_count;
        if (n == 0)
            n = 1;
        if (n > TB_MAX_STEPS)
            n = TB_MAX_STEPS;
        if (n > FIELD_SLOTS)
            n = FIELD_SLOTS;
        return n;
    endfunction

    // Advance the sequencer by one beat and return the result it produces
    function automatic match_result_t advance_sequencer(logic k, cond_t c);
        match_result_t r;
        step_kind_t    code;
        logic          cond_now;
        logic          done;
        logic [15:0]   lim_min;
        logic [15:0]   lim_max;
        logic [15:0]   lim_hold;
        r = '0;
        if (k == ITEM_REARM)
        begin
            if (!seq_armed)
            begin
                seq_armed = 1'b1;
                restart_sequence();
                r.rearm_accepted = 1'b1;
            end
        end
        else if (seq_armed)
        begin
            code     = step_kind_t'(cfg_kinds[2*seq_step +: 2]);
            cond_now = c[seq_step];
            lim_min  = cfg_min[SLOT_BITS*seq_step +: SLOT_BITS];
            lim_max  = cfg_max[SLOT_BITS*seq_step +: SLOT_BITS];
            lim_hold = cfg_hold[SLOT_BITS*seq_step +: SLOT_BITS];
            done     = 1'b0;
            case (code)
                STEP_WITHIN:
                begin
                    if (seq_age < AGE_TOP)
                        seq_age = seq_age + 1'b1;
                    // Age past the window: drop back to the first step
                    if (seq_age > {1'b0, lim_max})
                        restart_sequence();
                    else
                        done = (seq_age >= {1'b0, lim_min}) && cond_now;
                end
                STEP_HOLD:
                begin
                    if (!cond_now)
                        seq_held = '0;
                    else if (seq_held < HELD_TOP)
                        seq_held = seq_held + 1'b1;
                    done = (seq_held >= lim_hold);
                end
                default:
                    done = cond_now;
            endcase
            if (done)
            begin
                seq_age  = '0;
                seq_held = '0;
                if (int'(seq_step) + 1 >= int'(active_steps()))
                begin
                    seq_step  = '0;
                    seq_armed = 1'b0;
                    r.hit     = 1'b1;
                end
                else
                    seq_step = seq_step + 1'b1;
            end
        end
        r.armed_now    = seq_armed;
        r.current_step = seq_step;
        return r;
    endfunction

    // Receiver: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            result_ch.ready = 1'b0;
            hold_off_left   = hold_off_left - 1;
        end
        else
            result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest pending match
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("result beat with no pending match");
                mismatch_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (result_ch.hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, result_ch.hit);
                    mismatch_count++;
                end
                if (result_ch.rearm_accepted !== want.rearm_accepted)
                begin
                    $error("rearm_accepted: expected %0d, actual %0d",
                           want.rearm_accepted, result_ch.rearm_accepted);
                    mismatch_count++;
                end
                if (result_ch.armed_now !== want.armed_now)
                begin
                    $error("armed_now: expected %0d, actual %0d",
                           want.armed_now, result_ch.armed_now);
                    mismatch_count++;
                end
                if (result_ch.current_step !== want.current_step)
                begin
                    $error("current_step: expected %0d, actual %0d",
                           want.current_step, result_ch.current_step);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one tick or rearm beat; entered and left at a falling edge
    task automatic send_beat(logic k, cond_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid     = 1'b1;
        tick_ch.kind      = k;
        tick_ch.cond_bits = c;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        // Queue the expected result behind the older ones
        pending_matches = {pending_matches, advance_sequencer(k, c)};
        @(negedge clk);
        tick_ch.valid = 1'b0;
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_STEP_COUNT:     cfg_count = val[COUNT_REG_W-1:0];
            REG_STEP_KINDS:     cfg_kinds = val[KINDS_W-1:0];
            REG_WITHIN_MINIMUM: cfg_min   = val;
            REG_WITHIN_MAXIMUM: cfg_max   = val;
            REG_HOLD_CYCLES:    cfg_hold  = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic program_sequence(cfg_data_t count, cfg_data_t kinds, cfg_data_t min_ages,
                                    cfg_data_t max_ages, cfg_data_t holds);
        write_reg(REG_STEP_COUNT, count);
        write_reg(REG_STEP_KINDS, kinds);
        write_reg(REG_WITHIN_MINIMUM, min_ages);
        write_reg(REG_WITHIN_MAXIMUM, max_ages);
        write_reg(REG_HOLD_CYCLES, holds);
    endtask

    // Wait until every pending match has come back, then let the pipe settle
    task automatic wait_drain();
        while (pending_matches.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic cfg_data_t slot_value(int unsigned slot, logic [15:0] v);
        return cfg_data_t'(v) << (SLOT_BITS * slot);
    endfunction

    function automatic cfg_data_t random_limits(int unsigned top);
        cfg_data_t v = '0;
        for (int s = 0; s < FIELD_SLOTS; s++)
        begin
            if ($urandom_range(15) == 0)
                v[SLOT_BITS*s +: SLOT_BITS] = 16'hFFFF;
            else
                v[SLOT_BITS*s +: SLOT_BITS] = 16'($urandom_range(top));
        end
        return v;
    endfunction

    task automatic program_random_sequence();
        program_sequence({$urandom, $urandom}, {$urandom, $urandom},
                         random_limits(5), random_limits(10), random_limits(4));
    endtask

    // Mostly well-formed progress: favor the current step's condition, rearm when done
    task automatic send_random_ticks(int unsigned n);
        logic  k;
        cond_t c;
        repeat (n)
        begin
            c = cond_t'($urandom_range(15));
            if ($urandom_range(99) < 65)
                c[seq_step] = 1'b1;
            if (!seq_armed)
                k = ($urandom_range(99) < 60) ? ITEM_REARM : ITEM_TICK;
            else
                k = ($urandom_range(99) < 3) ? ITEM_REARM : ITEM_TICK;
            send_beat(k, c);
        end
    endtask

    // Reset defaults: one wait step; refused and accepted rearm, disarmed tick
    task automatic test_reset_defaults();
        send_beat(ITEM_REARM, 4'b1111);
        send_beat(ITEM_TICK, 4'b1110);
        send_beat(ITEM_TICK, 4'b0001);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_REARM, 4'b0000);
        wait_drain();
    endtask

    // One step of each kind in turn, spare code last
    task automatic test_step_kinds();
        program_sequence(cfg_data_t'(4),
                         cfg_data_t'({STEP_SPARE, STEP_HOLD, STEP_WITHIN, STEP_WAIT}),
                         slot_value(1, 16'd2), slot_value(1, 16'd3), slot_value(2, 16'd2));
        send_beat(ITEM_TICK, 4'b0001);
        send_beat(ITEM_TICK, 4'b0010);
        send_beat(ITEM_TICK, 4'b0010);
        send_beat(ITEM_TICK, 4'b0100);
        send_beat(ITEM_TICK, 4'b0000);
        send_beat(ITEM_TICK, 4'b0100);
        send_beat(ITEM_TICK, 4'b0100);
        send_beat(ITEM_TICK, 4'b1000);
        send_beat(ITEM_REARM, 4'b1111);
        wait_drain();
    endtask

    // Window with maximum below minimum restarts; widest window completes
    task automatic test_within_window();
        program_sequence(cfg_data_t'(1), cfg_data_t'(STEP_WITHIN),
                         slot_value(0, 16'd5), slot_value(0, 16'd2), '0);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_TICK, 4'b1111);
        wait_drain();
        program_sequence(cfg_data_t'(1), cfg_data_t'(STEP_WITHIN), '0, '1, '0);
        send_beat(ITEM_TICK, 4'b0000);
        send_beat(ITEM_TICK, 4'b0001);
        send_beat(ITEM_REARM, 4'b0101);
        wait_drain();
    endtask

    // Zero step count with a zero-length hold, then an oversized count
    task automatic test_count_limits();
        program_sequence(cfg_data_t'(0), cfg_data_t'(STEP_HOLD), '0, '0, '0);
        send_beat(ITEM_TICK, 4'b0000);
        send_beat(ITEM_REARM, 4'b0000);
        wait_drain();
        program_sequence(cfg_data_t'(7), '0, '0, '0, '0);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_TICK, 4'b1111);
        send_beat(ITEM_REARM, 4'b1010);
        wait_drain();
    endtask

    // Lower the count while a later step is current; unused indexes ignored
    task automatic test_index_beyond_count();
        program_sequence(cfg_data_t'(4), '0, '0, '0, '0);
        send_beat(ITEM_TICK, 4'b0001);
        send_beat(ITEM_TICK, 4'b0010);
        send_beat(ITEM_TICK, 4'b0100);
        wait_drain();
        write_reg(REG_STEP_COUNT, cfg_data_t'(2));
        write_reg(REG_UNUSED_LO, {$urandom, $urandom});
        write_reg(REG_UNUSED_HI, '1);
        send_beat(ITEM_TICK, 4'b1000);
        send_beat(ITEM_REARM, 4'b0000);
        wait_drain();
    endtask

    // Hold off the receiver so the block fills and stalls ticks, then pause
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_random_sequence();
        hold_off_left = 400;
        send_random_ticks(60);
        wait_drain();
        send_random_ticks(30);
        wait_drain();
    endtask

    // Random sequences over four idle/stall mixes, extremes at both ends
    task automatic test_random_sequences();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (phase == 0)
                program_sequence('0, '0, '0, '0, '0);
            else if (phase == 7)
                program_sequence('1, '1, '1, '1, '1);
            else
                program_random_sequence();
            send_random_ticks(235);
            wait_drain();
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.kind      = ITEM_TICK;
        tick_ch.cond_bits = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_STEP_COUNT;
        cfg_ch.data       = '0;
        result_ch.ready   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_step_kinds();
        test_within_window();
        test_count_limits();
        test_index_beyond_count();
        test_backpressure();
        test_random_sequences();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
